>>> hw/rtl/eth_ip_l4_header_parser_unit_defines.svh
// assertion macros for the header parser
`ifndef ETH_IP_L4_HEADER_PARSER_UNIT_DEFINES_SVH
`define ETH_IP_L4_HEADER_PARSER_UNIT_DEFINES_SVH

// implication checked on every clock edge outside reset
`define EHP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define EHP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/ehp_pkg.sv
package ehp_pkg;

  localparam int unsigned CountLimit = 127;
  localparam int unsigned CntW = 7;
  localparam int unsigned QDepth = 2;

  localparam logic [15:0] EthVlan = 16'h8100;
  localparam logic [15:0] EthIpv4 = 16'h0800;
  localparam logic [15:0] EthArp = 16'h0806;
  localparam logic [15:0] EthIpv6 = 16'h86DD;

  localparam logic [7:0] ProtoIcmp = 8'd1;
  localparam logic [7:0] ProtoTcp = 8'd6;
  localparam logic [7:0] ProtoUdp = 8'd17;

  typedef enum logic [3:0] {
    CLS_UNKNOWN = 4'd0, CLS_TCP = 4'd1, CLS_UDP = 4'd2, CLS_ICMP = 4'd3,
    CLS_ARP = 4'd4, CLS_IPV6 = 4'd5, CLS_DNS = 4'd6, CLS_HTTP = 4'd7,
    CLS_HTTPS = 4'd8, CLS_SSH = 4'd9, CLS_FTP = 4'd10, CLS_SMTP = 4'd11,
    CLS_DHCP = 4'd12, CLS_SNMP = 4'd13, CLS_TELNET = 4'd14
  } cls_t;

  // one accepted byte, tagged with its offset
  typedef struct packed {
    logic [7:0] data;
    logic last;
    logic [CntW-1:0] offset;
    logic live;
  } ev_t;

  typedef struct packed {
    logic [47:0] dst_mac;
    logic [47:0] src_mac;
    logic [15:0] icmp_type_code;
    logic [5:0] tcp_flag_bits;
    logic [15:0] dport;
    logic [15:0] sport;
    logic [31:0] dst_ip;
    logic [31:0] src_ip;
    logic [7:0] ip_proto;
    logic [15:0] ether_kind;
    logic [3:0] proto_class;
    logic frame_ok;
  } sum_t;

  function automatic cls_t port_class(input logic [15:0] p);
    cls_t c;
    c = CLS_UNKNOWN;
    case (p)
      16'd53: c = CLS_DNS;
      16'd80: c = CLS_HTTP;
      16'd443: c = CLS_HTTPS;
      16'd22: c = CLS_SSH;
      16'd21: c = CLS_FTP;
      16'd25, 16'd587: c = CLS_SMTP;
      16'd67, 16'd68: c = CLS_DHCP;
      16'd161, 16'd162: c = CLS_SNMP;
      16'd23: c = CLS_TELNET;
      default: c = CLS_UNKNOWN;
    endcase
    return c;
  endfunction

endpackage

>>> hw/rtl/ehp_front.sv
module ehp_front (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic [7:0] in_data,
  input  logic in_last,
  output logic in_ready,
  output ehp_pkg::ev_t ev,
  output logic ev_valid,
  input  logic ev_ready
);

  logic [ehp_pkg::CntW-1:0] byte_count;
  logic [1:0] fill;
  ehp_pkg::ev_t q [ehp_pkg::QDepth];
  logic wr_ptr, rd_ptr;
  logic push, pop;

  assign in_ready = (fill != 2'(ehp_pkg::QDepth));
  assign push = in_valid && in_ready;
  assign ev_valid = (fill != 2'd0);
  assign pop = ev_valid && ev_ready;
  assign ev = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      fill <= '0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) begin
        if (in_last) begin
          byte_count <= '0;
        end else if (byte_count < ehp_pkg::CntW'(ehp_pkg::CountLimit)) begin
          byte_count <= byte_count + 1'b1;
        end
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr].data <= in_data;
      q[wr_ptr].last <= in_last;
      q[wr_ptr].offset <= byte_count;
      q[wr_ptr].live <= (byte_count < ehp_pkg::CntW'(ehp_pkg::CountLimit));
    end
  end

endmodule

>>> hw/rtl/ehp_back.sv
module ehp_back (
  input  logic clk,
  input  logic rst,
  input  ehp_pkg::ev_t ev,
  input  logic ev_valid,
  output logic ev_ready,
  output ehp_pkg::sum_t sum,
  output logic sum_valid,
  input  logic sum_ready
);

  logic [15:0] eth_type_reg;
  logic [3:0] header_words;
  logic [3:0] ip_version_reg;
  logic [7:0] ip_proto_reg;
  logic [31:0] addr_regs [2];
  logic [47:0] mac_regs [2];
  logic [47:0] arp_mac [2];
  logic [15:0] port_regs [2];
  logic [5:0] flags_reg;
  logic [15:0] icmp_reg;
  logic vlan_seen;
  logic [ehp_pkg::CntW-1:0] len;

  logic take;
  logic [7:0] b;
  logic [ehp_pkg::CntW-1:0] c, r, hdr, s;
  logic [ehp_pkg::CntW:0] r_wide, s_wide;
  logic [15:0] eth_shift;
  logic ip_ok;

  logic [15:0] eth_type_reg_n;
  logic [3:0] hw_n, ver_n;
  logic [7:0] pr_n;
  logic [31:0] a0_n, a1_n;
  logic [47:0] m0_n, m1_n, am0_n, am1_n;
  logic [15:0] p0_n, p1_n, ic_n;
  logic [5:0] fl_n;
  logic vlan_n;
  logic [ehp_pkg::CntW-1:0] len_n;

  // summary of the state after this last byte is captured
  ehp_pkg::sum_t fin;
  logic [ehp_pkg::CntW-1:0] rem, tr;
  logic [ehp_pkg::CntW:0] tr_wide;
  ehp_pkg::cls_t pc;

  assign ev_ready = !sum_valid || sum_ready;
  assign take = ev_valid && ev_ready;
  assign b = ev.data;
  assign c = ev.offset;
  assign eth_shift = {eth_type_reg[7:0], b};
  assign r_wide = {1'b0, c} - (vlan_seen ? (ehp_pkg::CntW+1)'(18) : (ehp_pkg::CntW+1)'(14));
  assign r = r_wide[ehp_pkg::CntW-1:0];
  assign hdr = {1'b0, header_words, 2'b00};
  assign s_wide = {1'b0, r} - {1'b0, hdr};
  assign s = s_wide[ehp_pkg::CntW-1:0];
  assign ip_ok = ip_version_reg == 4'd4 && header_words >= 4'd5 && !s_wide[ehp_pkg::CntW];

  always_comb begin
    eth_type_reg_n = eth_type_reg;
    hw_n = header_words; ver_n = ip_version_reg; pr_n = ip_proto_reg;
    a0_n = addr_regs[0]; a1_n = addr_regs[1];
    m0_n = mac_regs[0]; m1_n = mac_regs[1];
    am0_n = arp_mac[0]; am1_n = arp_mac[1];
    p0_n = port_regs[0]; p1_n = port_regs[1];
    fl_n = flags_reg; ic_n = icmp_reg; vlan_n = vlan_seen;
    len_n = len;
    if (ev.live) begin
      len_n = c + 1'b1;
      if (c < 6) m1_n = {mac_regs[1][39:0], b};
      else if (c < 12) m0_n = {mac_regs[0][39:0], b};
      else if (c < 14) begin
        eth_type_reg_n = eth_shift;
        if (c == 13) vlan_n = (eth_shift == ehp_pkg::EthVlan);
      end else if (vlan_seen && c < 18) begin
        if (c >= 16) eth_type_reg_n = eth_shift;
      end else if (eth_type_reg == ehp_pkg::EthIpv4) begin
        if (r == 0) begin
          ver_n = b[7:4]; hw_n = b[3:0];
        end else if (r == 9) pr_n = b;
        else if (r >= 12 && r < 16) a0_n = {addr_regs[0][23:0], b};
        else if (r >= 16 && r < 20) a1_n = {addr_regs[1][23:0], b};
        else if (ip_ok) begin
          if (ip_proto_reg == ehp_pkg::ProtoTcp || ip_proto_reg == ehp_pkg::ProtoUdp) begin
            if (s < 2) p0_n = {port_regs[0][7:0], b};
            else if (s < 4) p1_n = {port_regs[1][7:0], b};
            else if (s == 13 && ip_proto_reg == ehp_pkg::ProtoTcp) fl_n = b[5:0];
          end else if (ip_proto_reg == ehp_pkg::ProtoIcmp && s < 2) begin
            ic_n = {icmp_reg[7:0], b};
          end
        end
      end else if (eth_type_reg == ehp_pkg::EthArp) begin
        if (r >= 8 && r < 14) am0_n = {arp_mac[0][39:0], b};
        else if (r >= 14 && r < 18) a0_n = {addr_regs[0][23:0], b};
        else if (r >= 18 && r < 24) am1_n = {arp_mac[1][39:0], b};
        else if (r >= 24 && r < 28) a1_n = {addr_regs[1][23:0], b};
      end
    end
  end

  always_comb begin
    fin = '0;
    pc = ehp_pkg::CLS_UNKNOWN;
    rem = len_n - (vlan_n ? ehp_pkg::CntW'(18) : ehp_pkg::CntW'(14));
    tr_wide = {1'b0, rem} - {2'b00, hw_n, 2'b00};
    tr = tr_wide[ehp_pkg::CntW-1:0];
    if (len_n >= 14 && (!vlan_n || len_n >= 18)) begin
      fin.frame_ok = 1'b1;
      fin.ether_kind = eth_type_reg_n;
      fin.src_mac = m0_n;
      fin.dst_mac = m1_n;
      if (eth_type_reg_n == ehp_pkg::EthIpv4) begin
        if (rem >= 20 && ver_n == 4'd4 && hw_n >= 4'd5 && !tr_wide[ehp_pkg::CntW]) begin
          fin.ip_proto = pr_n;
          fin.src_ip = a0_n;
          fin.dst_ip = a1_n;
          if (pr_n == ehp_pkg::ProtoTcp && tr >= 20) begin
            fin.sport = p0_n; fin.dport = p1_n; fin.tcp_flag_bits = fl_n;
            pc = ehp_pkg::CLS_TCP;
          end else if (pr_n == ehp_pkg::ProtoUdp && tr >= 8) begin
            fin.sport = p0_n; fin.dport = p1_n;
            pc = ehp_pkg::CLS_UDP;
          end else if (pr_n == ehp_pkg::ProtoIcmp && tr >= 8) begin
            fin.icmp_type_code = ic_n;
            fin.proto_class = ehp_pkg::CLS_ICMP;
          end
          if (pc != ehp_pkg::CLS_UNKNOWN) begin
            if (ehp_pkg::port_class(p1_n) != ehp_pkg::CLS_UNKNOWN)
              fin.proto_class = ehp_pkg::port_class(p1_n);
            else if (ehp_pkg::port_class(p0_n) != ehp_pkg::CLS_UNKNOWN)
              fin.proto_class = ehp_pkg::port_class(p0_n);
            else fin.proto_class = pc;
          end
        end
      end else if (eth_type_reg_n == ehp_pkg::EthArp) begin
        if (rem >= 28) begin
          fin.src_ip = a0_n; fin.dst_ip = a1_n;
          fin.src_mac = am0_n; fin.dst_mac = am1_n;
          fin.proto_class = ehp_pkg::CLS_ARP;
        end
      end else if (eth_type_reg_n == ehp_pkg::EthIpv6) begin
        fin.proto_class = ehp_pkg::CLS_IPV6;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= 1'b0;
      eth_type_reg <= '0; header_words <= '0; ip_version_reg <= '0; ip_proto_reg <= '0;
      addr_regs[0] <= '0; addr_regs[1] <= '0; mac_regs[0] <= '0; mac_regs[1] <= '0;
      arp_mac[0] <= '0; arp_mac[1] <= '0; port_regs[0] <= '0; port_regs[1] <= '0;
      flags_reg <= '0; icmp_reg <= '0; vlan_seen <= 1'b0; len <= '0;
    end else begin
      if (sum_valid && sum_ready) sum_valid <= 1'b0;
      if (take) begin
        if (ev.last) begin
          sum_valid <= 1'b1;
          eth_type_reg <= '0; header_words <= '0; ip_version_reg <= '0; ip_proto_reg <= '0;
          addr_regs[0] <= '0; addr_regs[1] <= '0; mac_regs[0] <= '0; mac_regs[1] <= '0;
          arp_mac[0] <= '0; arp_mac[1] <= '0; port_regs[0] <= '0; port_regs[1] <= '0;
          flags_reg <= '0; icmp_reg <= '0; vlan_seen <= 1'b0; len <= '0;
        end else begin
          eth_type_reg <= eth_type_reg_n; header_words <= hw_n;
          ip_version_reg <= ver_n; ip_proto_reg <= pr_n;
          addr_regs[0] <= a0_n; addr_regs[1] <= a1_n;
          mac_regs[0] <= m0_n; mac_regs[1] <= m1_n;
          arp_mac[0] <= am0_n; arp_mac[1] <= am1_n;
          port_regs[0] <= p0_n; port_regs[1] <= p1_n;
          flags_reg <= fl_n; icmp_reg <= ic_n; vlan_seen <= vlan_n; len <= len_n;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && ev.last) sum <= fin;
  end

endmodule

>>> hw/rtl/eth_ip_l4_header_parser_unit.sv
// ethernet / ipv4 / tcp-udp-icmp / arp header parser
// s_axis carries one frame byte per transfer, tlast on the final byte
// of the frame; m_axis carries one 243-bit summary per frame, zero padded
// to 248 bits, sent after the transfer that carries tlast
// the front stage counts byte offsets and writes each byte into a
// two-entry queue; the back stage captures header fields by offset
// throughput: one byte per cycle while m_axis is not stalled, set by the single
// capture update per byte in the back stage
// the last byte transfer is written into the queue, then loads the output
// register, which raises m_axis_tvalid
// the byte offset saturates at 127; bytes at offset 127 and beyond are ignored
// reset clears the queue, the capture registers and the output valid
// when m_axis stalls the output register holds, the back stage stops
// and the queue fills; s_axis_tready drops once two bytes are waiting
`include "eth_ip_l4_header_parser_unit_defines.svh"
module eth_ip_l4_header_parser_unit (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // frame_byte
  input  logic s_axis_tlast,         // end_of_frame
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // frame_ok, proto_class, ether_kind, ip_proto, src_ip, dst_ip, sport,
  // dport, tcp_flag_bits, icmp_type_code, src_mac, dst_mac, zero pad
  output logic [247:0] m_axis_tdata
);

  ehp_pkg::ev_t ev;
  logic ev_valid, ev_ready;
  ehp_pkg::sum_t sum;

  // front: offset tagging and queue
  ehp_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_data(s_axis_tdata), .in_last(s_axis_tlast),
    .in_ready(s_axis_tready),
    .ev(ev), .ev_valid(ev_valid), .ev_ready(ev_ready)
  );

  // back: field capture and summary register
  ehp_back u_back (
    .clk(clk), .rst(rst),
    .ev(ev), .ev_valid(ev_valid), .ev_ready(ev_ready),
    .sum(sum), .sum_valid(m_axis_tvalid), .sum_ready(m_axis_tready)
  );

  // struct is packed msb-first, so first field lands in the high bits
  assign m_axis_tdata = {5'd0, sum};

  `EHP_ASSERT_IMP(a_ok_fields, m_axis_tvalid && !sum.frame_ok,
    sum.proto_class == 4'd0 && sum.src_mac == 48'd0, "fields set on short frame")
  `EHP_ASSERT_IMP(a_class_range, m_axis_tvalid, sum.proto_class <= 4'd14,
    "class out of range")
  `EHP_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(sum), "summary dropped under stall")

endmodule
